>>> hw/rtl/fbik_pkg.sv
`default_nettype none

package fbik_pkg;

  // Register map (word index within the configuration space)
  localparam logic [2:0] REG_MIN_LEN  = 3'd0;
  localparam logic [2:0] REG_MAX_LEN  = 3'd1;
  localparam logic [2:0] REG_CRANK    = 3'd2;
  localparam logic [2:0] REG_ROD      = 3'd3;
  localparam logic [2:0] REG_HIP_HALF = 3'd4;

  localparam logic [15:0] RST_MIN_LEN  = 16'd5243;
  localparam logic [15:0] RST_MAX_LEN  = 16'd14418;
  localparam logic [15:0] RST_CRANK    = 16'd6095;
  localparam logic [15:0] RST_ROD      = 16'd9765;
  localparam logic [15:0] RST_HIP_HALF = 16'd1704;

  // Square root: 34-bit radicand, 17-bit root, one root bit per stage
  localparam int SQ_N  = 17;
  localparam int RAD_W = 34;

  // Division: 18 quotient bits, one per stage
  localparam int DIV_N = 18;
  localparam int DIV_W = 52;

  // CORDIC datapath
  localparam int CORD_W   = 45;
  localparam int Z_W      = 33;
  localparam int ANG_W    = 36;
  localparam int ACC_FRAC = 30;
  localparam int TAB_LEN  = 24;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 33'sd1686629713;

  // atan(2^-i) in units of 2^-30 rad, rounded
  localparam logic [30:0] ATAN_TAB [TAB_LEN] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
    31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
    31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
    31'd262144,    31'd131072,    31'd65536,     31'd32768,
    31'd16384,     31'd8192,      31'd4096,      31'd2048,
    31'd1024,      31'd512,       31'd256,       31'd128
  };

  typedef struct packed {
    logic [18:0] rem;
    logic [16:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_N-1:0] q;
    logic [33:0]      den;
    logic             sat;
    logic             one;
    logic             neg;
  } div_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [Z_W-1:0]    z;
    logic                     yz;
    logic                     xz;
  } cordic_t;

  // Side data travelling with every item
  typedef struct packed {
    logic [15:0] d;
    logic        oor;
    logic        cneg;
    logic [16:0] ac;
  } side_t;

  // One digit of the restoring square root
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] bits);
    logic [18:0] r4;
    logic [18:0] trial;
    sqrt_t       o;
    r4    = {s.rem[16:0], bits};
    trial = {1'b0, s.root[15:0], 2'b01};
    if (r4 >= trial) begin
      o.rem  = r4 - trial;
      o.root = {s.root[15:0], 1'b1};
    end else begin
      o.rem  = r4;
      o.root = {s.root[15:0], 1'b0};
    end
    return o;
  endfunction

  // One vectoring CORDIC rotation
  function automatic cordic_t cordic_step(cordic_t c, logic [4:0] idx);
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    logic signed [Z_W-1:0]    dz;
    cordic_t                  o;
    dx = $signed(c.y) >>> idx;
    dy = $signed(c.x) >>> idx;
    dz = $signed({2'b00, ATAN_TAB[idx]});
    o  = c;
    if (!c.y[CORD_W-1]) begin
      o.x = $signed(c.x) + dx;
      o.y = $signed(c.y) - dy;
      o.z = $signed(c.z) + dz;
    end else begin
      o.x = $signed(c.x) - dx;
      o.y = $signed(c.y) + dy;
      o.z = $signed(c.z) - dz;
    end
    return o;
  endfunction

  // Final first-quadrant angle with the exact axis cases
  function automatic logic signed [Z_W-1:0] cordic_angle(cordic_t c);
    if (c.yz) begin
      return '0;
    end else if (c.xz) begin
      return HALF_PI_Q30;
    end
    return $signed(c.z);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fbik_if.sv
`default_nettype none

// Leg length request channel
interface fbik_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] leg_length;
  modport source (output valid, output leg_length, input ready);
  modport sink   (input valid, input leg_length, output ready);
endinterface

// Servo angle result channel
interface fbik_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] back_angle;
  logic signed [16:0] front_angle;
  logic               out_of_reach;
  modport source (output valid, output back_angle, output front_angle,
                  output out_of_reach, input ready);
  modport sink   (input valid, input back_angle, input front_angle,
                  input out_of_reach, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/five_bar_leg_inverse_kinematics_top.sv
// Five-bar leg inverse kinematics.
// in_if carries a requested leg length (Q0.16 m); out_if returns the back and
// front servo angles (2^-ANGLE_FRAC_BITS rad) and an out-of-reach flag. Each
// channel moves one item per transfer (valid and ready both high).
// The link sizes and length limits sit in five APB registers at 4*i; write
// them only while no item is in flight. cfg_pready is always high.
// Throughput: one item per cycle while in_if.ready is high. The pipeline runs
// from the input transfer to out_if.valid through two 17-stage
// square roots, an 18-stage divider and the CORDIC stages.
// Reset (synchronous, rst_n low) empties the pipeline and loads the default
// link geometry; nothing is lost since no item may be in flight then.
// When the receiver stalls, the result holds in the output register and the
// pipeline keeps advancing into empty slots; in_if.ready drops only once the
// last stage also holds a result.
`default_nettype none

module five_bar_leg_inverse_kinematics_top #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int CORDIC_STAGES   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  fbik_in_if.sink            in_if,
  fbik_out_if.source         out_if,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [4:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic      [31:0]   cfg_prdata,
  output logic               cfg_pready
);

  localparam int SQ_N   = fbik_pkg::SQ_N;
  localparam int DIV_N  = fbik_pkg::DIV_N;
  localparam int DIV_W  = fbik_pkg::DIV_W;
  localparam int ANG_W  = fbik_pkg::ANG_W;
  localparam int Z_W    = fbik_pkg::Z_W;

  // Stage positions along the pipeline
  localparam int ST_NUM   = 2 + SQ_N;
  localparam int ST_PREP  = ST_NUM + 1;
  localparam int ST_DIV0  = ST_PREP + 1;
  localparam int ST_AC    = ST_DIV0 + DIV_N;
  localparam int ST_RAD   = ST_AC + 1;
  localparam int ST_SQ2   = ST_RAD + 1;
  localparam int ST_CINIT = ST_SQ2 + SQ_N;
  localparam int ST_COMB  = ST_CINIT + CORDIC_STAGES + 1;
  localparam int N_ST     = ST_COMB + 1;

  localparam int RND_SH = fbik_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] RND_HALF = ANG_W'(1) <<< (RND_SH - 1);

  // ---------------------------------------------------------------- config
  logic [15:0] min_len_r, max_len_r, crank_r, rod_r, hip_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= fbik_pkg::RST_MIN_LEN;
      max_len_r <= fbik_pkg::RST_MAX_LEN;
      crank_r   <= fbik_pkg::RST_CRANK;
      rod_r     <= fbik_pkg::RST_ROD;
      hip_r     <= fbik_pkg::RST_HIP_HALF;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        fbik_pkg::REG_MIN_LEN:  min_len_r <= cfg_pwdata[15:0];
        fbik_pkg::REG_MAX_LEN:  max_len_r <= cfg_pwdata[15:0];
        fbik_pkg::REG_CRANK:    crank_r   <= cfg_pwdata[15:0];
        fbik_pkg::REG_ROD:      rod_r     <= cfg_pwdata[15:0];
        fbik_pkg::REG_HIP_HALF: hip_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      fbik_pkg::REG_MIN_LEN:  cfg_prdata = {16'h0000, min_len_r};
      fbik_pkg::REG_MAX_LEN:  cfg_prdata = {16'h0000, max_len_r};
      fbik_pkg::REG_CRANK:    cfg_prdata = {16'h0000, crank_r};
      fbik_pkg::REG_ROD:      cfg_prdata = {16'h0000, rod_r};
      fbik_pkg::REG_HIP_HALF: cfg_prdata = {16'h0000, hip_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------- flow control
  logic              pipe_adv;
  logic              in_acc;
  logic [N_ST-1:0]   vld_r;
  logic              out_valid_r;
  logic              out_free;

  assign out_free  = !out_valid_r || out_if.ready;
  assign pipe_adv  = out_free || !vld_r[N_ST-1];
  assign in_if.ready = pipe_adv;
  assign in_acc    = in_if.valid && pipe_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_adv) begin
      vld_r <= {vld_r[N_ST-2:0], in_acc};
    end
  end

  // ------------------------------------------------------ side data
  fbik_pkg::side_t side_r   [N_ST];
  fbik_pkg::side_t side_nxt [N_ST];
  logic [15:0]     d_clamp;
  logic            reach_fail;
  logic [16:0]     ac_w;
  logic            cneg_w;

  // Clamp: lower limit tested first
  always_comb begin
    if (in_if.leg_length < min_len_r) begin
      d_clamp = min_len_r;
    end else if (in_if.leg_length > max_len_r) begin
      d_clamp = max_len_r;
    end else begin
      d_clamp = in_if.leg_length;
    end
  end

  always_comb begin
    side_nxt[0].d    = d_clamp;
    side_nxt[0].oor  = 1'b0;
    side_nxt[0].cneg = 1'b0;
    side_nxt[0].ac   = '0;
    for (int k = 1; k < N_ST; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    side_nxt[ST_NUM].oor  = reach_fail;
    side_nxt[ST_AC].ac    = ac_w;
    side_nxt[ST_AC].cneg  = cneg_w;
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      for (int k = 0; k < N_ST; k++) begin
        side_r[k] <= side_nxt[k];
      end
    end
  end

  // ------------------------------------------- squared distance w^2 + d^2
  logic [31:0] ww_w, dd_w;
  logic [32:0] l2_r;

  assign ww_w = hip_r * hip_r;
  assign dd_w = side_r[0].d * side_r[0].d;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      l2_r <= {1'b0, ww_w} + {1'b0, dd_w};
    end
  end

  // ------------------------------------------- first square root: L
  fbik_pkg::sqrt_t  sq1_r  [SQ_N];
  logic [fbik_pkg::RAD_W-1:0] rad1_r [SQ_N-1];

  for (genvar j = 0; j < SQ_N; j++) begin : g_sq1
    fbik_pkg::sqrt_t            s_in;
    logic [fbik_pkg::RAD_W-1:0] r_in;
    if (j == 0) begin : g_first
      assign s_in = '0;
      assign r_in = {1'b0, l2_r};
    end else begin : g_next
      assign s_in = sq1_r[j-1];
      assign r_in = rad1_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (pipe_adv) begin
        sq1_r[j] <= fbik_pkg::sqrt_step(s_in, r_in[fbik_pkg::RAD_W-1 -: 2]);
      end
    end
    if (j < SQ_N - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (pipe_adv) begin
          rad1_r[j] <= {r_in[fbik_pkg::RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  // ----------------------- reach test, cosine numerator and denominator
  logic [16:0]        len_w, ab_sum_w, ab_diff_w;
  logic [31:0]        aa_w, bb_w;
  logic [32:0]        alen_w;
  logic [32:0]        l2_d_r [SQ_N];
  logic signed [35:0] num_r;
  logic [33:0]        den_r;

  // L2 follows the root stages for the numerator
  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      l2_d_r[0] <= l2_r;
      for (int k = 1; k < SQ_N; k++) begin
        l2_d_r[k] <= l2_d_r[k-1];
      end
    end
  end

  assign len_w     = sq1_r[SQ_N-1].root;
  assign ab_sum_w  = {1'b0, crank_r} + {1'b0, rod_r};
  assign ab_diff_w = (crank_r > rod_r) ? {1'b0, crank_r - rod_r} : {1'b0, rod_r - crank_r};
  assign reach_fail = (len_w > ab_sum_w) || (len_w < ab_diff_w);
  assign aa_w      = crank_r * crank_r;
  assign bb_w      = rod_r * rod_r;
  assign alen_w    = {17'h00000, crank_r} * {16'h0000, len_w};

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      num_r <= $signed({4'h0, aa_w}) + $signed({3'h0, l2_d_r[SQ_N-1]})
               - $signed({4'h0, bb_w});
      den_r <= {alen_w, 1'b0};
    end
  end

  // ----------------------- magnitude, overflow and zero-divisor checks
  logic [35:0] mag_w;
  logic [35:0] mag_r;
  logic [33:0] pden_r;
  logic        sat_r, one_r, neg_r;

  assign mag_w = num_r[35] ? 36'(-num_r) : 36'(num_r);

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      mag_r  <= mag_w;
      pden_r <= den_r;
      sat_r  <= mag_w >= {den_r, 2'b00};
      one_r  <= den_r == '0;
      neg_r  <= num_r[35];
    end
  end

  // ---------------------------------- restoring divider, one bit a stage
  fbik_pkg::div_t div_r [DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    localparam int SH = DIV_N - 1 - k;
    fbik_pkg::div_t   dv_in;
    fbik_pkg::div_t   dv_out;
    logic [DIV_W-1:0] trial;
    if (k == 0) begin : g_first
      assign dv_in = {mag_r, 16'h0000, DIV_N'(0), pden_r, sat_r, one_r, neg_r};
    end else begin : g_next
      assign dv_in = div_r[k-1];
    end
    assign trial = DIV_W'(dv_in.den) << SH;
    always_comb begin
      dv_out = dv_in;
      if (dv_in.rem >= trial) begin
        dv_out.rem   = dv_in.rem - trial;
        dv_out.q[SH] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (pipe_adv) begin
        div_r[k] <= dv_out;
      end
    end
  end

  // |c| clamped to one, sign of c
  always_comb begin
    if (div_r[DIV_N-1].one || div_r[DIV_N-1].sat ||
        div_r[DIV_N-1].q > 18'h10000) begin
      ac_w = 17'h10000;
    end else begin
      ac_w = div_r[DIV_N-1].q[16:0];
    end
    cneg_w = div_r[DIV_N-1].neg && !div_r[DIV_N-1].one && (ac_w != '0);
  end

  // ------------------------------------------- radicand 1 - c^2
  logic [33:0] acsq_w;
  logic [fbik_pkg::RAD_W-1:0] rad2_r;

  assign acsq_w = {17'h00000, side_r[ST_AC].ac} * {17'h00000, side_r[ST_AC].ac};

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      rad2_r <= 34'h1_0000_0000 - acsq_w;
    end
  end

  // ------------------------------------------- second square root: sin
  fbik_pkg::sqrt_t            sq2_r  [SQ_N];
  logic [fbik_pkg::RAD_W-1:0] rad2s_r [SQ_N-1];

  for (genvar j = 0; j < SQ_N; j++) begin : g_sq2
    fbik_pkg::sqrt_t            s_in;
    logic [fbik_pkg::RAD_W-1:0] r_in;
    if (j == 0) begin : g_first
      assign s_in = '0;
      assign r_in = rad2_r;
    end else begin : g_next
      assign s_in = sq2_r[j-1];
      assign r_in = rad2s_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (pipe_adv) begin
        sq2_r[j] <= fbik_pkg::sqrt_step(s_in, r_in[fbik_pkg::RAD_W-1 -: 2]);
      end
    end
    if (j < SQ_N - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (pipe_adv) begin
          rad2s_r[j] <= {r_in[fbik_pkg::RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  // ------------------------------------------- CORDIC set-up
  // cor1: acos(|c|) = atan2(sin, |c|); cor2: bearing atan2(d, w)
  fbik_pkg::cordic_t cor1_r [CORDIC_STAGES+1];
  fbik_pkg::cordic_t cor2_r [CORDIC_STAGES+1];
  logic [16:0]       s_w;
  logic [16:0]       acx_w;
  logic [15:0]       dy_w;

  assign s_w   = sq2_r[SQ_N-1].root;
  assign acx_w = side_r[ST_CINIT-1].ac;
  assign dy_w  = side_r[ST_CINIT-1].d;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      cor1_r[0].x  <= $signed({4'h0, acx_w, 24'h000000});
      cor1_r[0].y  <= $signed({4'h0, s_w, 24'h000000});
      cor1_r[0].z  <= '0;
      cor1_r[0].yz <= s_w == '0;
      cor1_r[0].xz <= acx_w == '0;
      cor2_r[0].x  <= $signed({5'h00, hip_r, 24'h000000});
      cor2_r[0].y  <= $signed({5'h00, dy_w, 24'h000000});
      cor2_r[0].z  <= '0;
      cor2_r[0].yz <= dy_w == '0;
      cor2_r[0].xz <= hip_r == '0;
    end
  end

  // ------------------------------------------- CORDIC rotations
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (pipe_adv) begin
        cor1_r[i+1] <= fbik_pkg::cordic_step(cor1_r[i], 5'(i));
        cor2_r[i+1] <= fbik_pkg::cordic_step(cor2_r[i], 5'(i));
      end
    end
  end

  // ------------------------------------------- angle assembly and rounding
  logic signed [Z_W-1:0]   z1_w, z2_w;
  logic signed [ANG_W-1:0] ang_w, t_w, base1_w, base2_w, back_w, front_w;
  logic signed [ANG_W-1:0] back_rnd_w, front_rnd_w;
  logic signed [16:0]      back_r, front_r;
  logic                    oor_r;
  fbik_pkg::side_t         side_c;

  assign side_c = side_r[ST_COMB-1];
  assign z1_w   = fbik_pkg::cordic_angle(cor1_r[CORDIC_STAGES]);
  assign z2_w   = fbik_pkg::cordic_angle(cor2_r[CORDIC_STAGES]);

  always_comb begin
    ang_w   = side_c.cneg ? fbik_pkg::PI_Q30 - ANG_W'(z1_w) : ANG_W'(z1_w);
    t_w     = ANG_W'(z2_w);
    base1_w = -t_w;
    base2_w = (hip_r != '0) ? t_w - fbik_pkg::PI_Q30 : -t_w;
    back_w  = base1_w - ang_w;
    front_w = base2_w + ang_w;
    back_rnd_w  = (back_w + RND_HALF) >>> RND_SH;
    front_rnd_w = (front_w + RND_HALF) >>> RND_SH;
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      oor_r   <= side_c.oor;
      back_r  <= side_c.oor ? '0 : back_rnd_w[16:0];
      front_r <= side_c.oor ? '0 : front_rnd_w[16:0];
    end
  end

  // ------------------------------------------- output register
  logic signed [16:0] out_back_r, out_front_r;
  logic               out_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= vld_r[N_ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && vld_r[N_ST-1]) begin
      out_back_r  <= back_r;
      out_front_r <= front_r;
      out_oor_r   <= oor_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.back_angle   = out_back_r;
  assign out_if.front_angle  = out_front_r;
  assign out_if.out_of_reach = out_oor_r;

endmodule

`default_nettype wire

>>> hw/rtl/fbik_checker.sv
`default_nettype none

module fbik_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [16:0] back_angle,
  input wire logic signed [16:0] front_angle,
  input wire logic               out_of_reach
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(back_angle) &&
    $stable(front_angle) && $stable(out_of_reach))
    else $error("result changed while stalled");

  // Out of reach gives zero angles
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_reach |-> back_angle == 17'sd0 && front_angle == 17'sd0)
    else $error("non-zero angle on out-of-reach result");

  // Input side only blocks behind a stalled, full output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without an output stall");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result visible after reset");

endmodule

bind five_bar_leg_inverse_kinematics_top fbik_checker u_fbik_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .back_angle   (out_if.back_angle),
  .front_angle  (out_if.front_angle),
  .out_of_reach (out_if.out_of_reach)
);

`default_nettype wire
